>>> sv/text_terminal_char_buffer_macros.svh
// Assertion macros shared by the checker file of the character buffer.
`ifndef TEXT_TERMINAL_CHAR_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_CHAR_BUFFER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TTCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TTCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ttcb_pkg.sv
// Shared types, command codes and character constants of the character buffer.
package ttcb_pkg;

    localparam int DEF_COLS = 40;
    localparam int DEF_ROWS = 25;

    localparam int OP_W   = 4;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;

    localparam logic [OP_W-1:0] OP_PUT_CHAR   = 4'd0;
    localparam logic [OP_W-1:0] OP_PUT_HEX    = 4'd1;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd2;
    localparam logic [OP_W-1:0] OP_SCROLL_UP  = 4'd3;
    localparam logic [OP_W-1:0] OP_CURSOR_FWD = 4'd4;
    localparam logic [OP_W-1:0] OP_CR_LF      = 4'd5;
    localparam logic [OP_W-1:0] OP_LF         = 4'd6;
    localparam logic [OP_W-1:0] OP_SHOW       = 4'd7;
    localparam logic [OP_W-1:0] OP_HIDE       = 4'd8;
    localparam logic [OP_W-1:0] OP_READ_CELL  = 4'd9;

    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CURSOR_BIT = 8'h80;
    localparam logic [3:0]        NIBBLE_MASK = 4'hF;

    localparam logic [CHAR_W-1:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_value;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              cursor_visible;
    } t_out;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nibble);
        return HEX_DIGITS[nibble & NIBBLE_MASK];
    endfunction

endpackage

>>> sv/ttcb_addr.sv
// Shared address unit: maps a screen line through the rotation pointer to a cell address.
module ttcb_addr #(
    parameter int ROWS = 25,
    parameter int COLS = 40,
    parameter int RW   = 5,
    parameter int CW   = 6,
    parameter int AW   = 10
) (
    input  logic [RW-1:0] i_row,
    input  logic [CW-1:0] i_col,
    input  logic [RW-1:0] i_top,
    output logic [RW-1:0] o_phys,
    output logic [AW-1:0] o_addr
);

    logic [RW:0] sum;

    // With both operands below ROWS, one conditional subtract wraps the sum.
    assign sum    = {1'b0, i_row} + {1'b0, i_top};
    assign o_phys = (sum >= (RW+1)'(ROWS)) ? RW'(sum - (RW+1)'(ROWS)) : sum[RW-1:0];
    assign o_addr = AW'(AW'(o_phys) * AW'(COLS)) + AW'(i_col);

endmodule

>>> sv/ttcb_mem.sv
// Single-port cell store with registered read data.
module ttcb_mem #(
    parameter int DEPTH = 1000,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_addr,
    input  logic [ttcb_pkg::CHAR_W-1:0] i_wdata,
    output logic [ttcb_pkg::CHAR_W-1:0] o_rdata
);
    import ttcb_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/text_terminal_char_buffer.sv
// Top level of the text terminal character buffer: command sequencer, row map and result register.
//
// Usage:
//   One command enters on the input channel (i_in_valid / o_in_ready) as a t_in
//   transaction; exactly one t_out transaction leaves on the output channel
//   (o_out_valid / i_out_ready) with the cursor after the command and, for a
//   cell read, the stored byte with bit 7 flipped under a shown cursor.
//   o_in_ready is high only while the sequencer is idle. After S_EXEC decodes a
//   command, S_DONE loads the result (o_out_valid high after it), by way of:
//     show, hide, clear, scroll, cursor moves, unknown codes: no further state
//     read cell: S_RD, then S_RDW for the registered store read
//     put char: S_EMIT, with an S_CLR sweep when it lands in a row not yet cleared
//     put hex: S_EMIT per digit, CR and LF, with S_CLR sweeps for rows not yet cleared
//   The sequencer returns to idle after the result loads and takes the next command
//   there. The single store port and the shared address unit set the rate: every
//   cell write, row-clear step and read uses them.
//   Scrolling only moves the row-rotation pointer and marks the new bottom row
//   blank; a blank row is swept to zero before its first write.
//   Reset (synchronous, active low) marks every row blank at once, homes and
//   hides the cursor. A stalled receiver holds the result in the output register;
//   the next command is still accepted and its result waits until it frees.
module text_terminal_char_buffer #(
    parameter int COLS = ttcb_pkg::DEF_COLS,
    parameter int ROWS = ttcb_pkg::DEF_ROWS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ttcb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ttcb_pkg::t_out o_out_data
);
    import ttcb_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_EMIT = 7'b0000100,
        S_CLR  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_RDW  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Sequencer state and command registers.
    t_state            r_state, n_state;
    t_in               r_in, n_in;
    logic [1:0]        r_step, n_step;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic [CW-1:0]     r_sweep, n_sweep;
    logic              r_rd_ok, n_rd_ok;
    logic              r_hit, n_hit;
    logic [CHAR_W-1:0] r_cell, n_cell;

    // Cursor and row map.
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_line, n_line;
    logic [RW-1:0]     r_top, n_top;
    logic [ROWS-1:0]   r_vld, n_vld;
    logic              r_shown, n_shown;

    // Result register.
    t_out              r_out, n_out;
    logic              r_out_vld, n_out_vld;

    // Store and address unit.
    logic [RW-1:0]     au_row;
    logic [CW-1:0]     au_col;
    logic [RW-1:0]     au_phys;
    logic [AW-1:0]     au_addr;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;

    logic              do_adv;
    logic              do_nl;
    logic              step_done;
    logic              in_range;

    ttcb_addr #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW),
        .CW   (CW),
        .AW   (AW)
    ) u_addr (
        .i_row  (au_row),
        .i_col  (au_col),
        .i_top  (r_top),
        .o_phys (au_phys),
        .o_addr (au_addr)
    );

    ttcb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (au_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Steer the address unit: the read port for cell reads, the cursor line otherwise.
    always_comb begin
        au_row = (r_state == S_RD) ? RW'(r_in.read_row) : r_line;
        if (r_state == S_CLR) begin
            au_col = r_sweep;
        end else if (r_state == S_RD) begin
            au_col = CW'(r_in.read_col);
        end else begin
            au_col = r_col;
        end
    end

    assign in_range = (32'(r_in.read_row) < 32'(ROWS)) && (32'(r_in.read_col) < 32'(COLS));

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_step    = r_step;
        n_ch      = r_ch;
        n_sweep   = r_sweep;
        n_rd_ok   = r_rd_ok;
        n_hit     = r_hit;
        n_cell    = r_cell;
        n_col     = r_col;
        n_line    = r_line;
        n_top     = r_top;
        n_vld     = r_vld;
        n_shown   = r_shown;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        mem_we    = 1'b0;
        mem_wdata = r_ch;
        do_adv    = 1'b0;
        do_nl     = 1'b0;
        step_done = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_cell  = '0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_in.operation)
                    OP_PUT_CHAR: begin
                        n_ch    = r_in.char_code;
                        n_step  = 2'd3;
                        n_state = S_EMIT;
                    end
                    OP_PUT_HEX: begin
                        n_ch    = hex_char(r_in.char_code[7:4]);
                        n_step  = 2'd0;
                        n_state = S_EMIT;
                    end
                    OP_CLEAR: begin
                        n_vld  = '0;
                        n_top  = '0;
                        n_col  = '0;
                        n_line = '0;
                    end
                    OP_SCROLL_UP: begin
                        n_vld[r_top] = 1'b0;
                        n_top = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                    end
                    OP_CURSOR_FWD: do_adv = 1'b1;
                    OP_CR_LF: begin
                        n_col = '0;
                        do_nl = 1'b1;
                    end
                    OP_LF:        do_nl = 1'b1;
                    OP_SHOW:      n_shown = 1'b1;
                    OP_HIDE:      n_shown = 1'b0;
                    OP_READ_CELL: n_state = S_RD;
                    default: ;
                endcase
            end
            S_EMIT: begin
                if (r_ch == CH_CR) begin
                    n_col     = '0;
                    step_done = 1'b1;
                end else if (r_ch == CH_LF) begin
                    n_col     = '0;
                    do_nl     = 1'b1;
                    step_done = 1'b1;
                end else if (!r_vld[au_phys]) begin
                    // Blank row: sweep it to zero before the first write lands.
                    n_sweep = '0;
                    n_state = S_CLR;
                end else begin
                    mem_we    = 1'b1;
                    do_adv    = 1'b1;
                    step_done = 1'b1;
                end
            end
            S_CLR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_sweep == CW'(COLS - 1)) begin
                    n_vld[au_phys] = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_RD: begin
                n_rd_ok = in_range && r_vld[au_phys];
                n_hit   = r_shown && (32'(r_in.read_row) == 32'(r_line))
                          && (32'(r_in.read_col) == 32'(r_col));
                n_state = S_RDW;
            end
            S_RDW: begin
                n_cell  = (r_rd_ok ? mem_rdata : '0) ^ (r_hit ? CURSOR_BIT : '0);
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the result register is free.
                if (!r_out_vld || i_out_ready) begin
                    n_out.cell_value     = r_cell;
                    n_out.cursor_col     = COL_W'(r_col);
                    n_out.cursor_row     = ROW_W'(r_line);
                    n_out.cursor_visible = r_shown;
                    n_out_vld            = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance the sequence of emitted characters.
        if (step_done) begin
            if (r_step == 2'd3) begin
                n_state = S_DONE;
            end else begin
                n_step = r_step + 1'b1;
                case (r_step)
                    2'd0:    n_ch = hex_char(r_in.char_code[3:0]);
                    2'd1:    n_ch = CH_CR;
                    default: n_ch = CH_LF;
                endcase
            end
        end

        // Advance the cursor, wrapping at the right edge.
        if (do_adv) begin
            if (r_col == CW'(COLS - 1)) begin
                n_col = '0;
                do_nl = 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end

        // Next line; at the bottom, rotate the rows and blank the new bottom row.
        if (do_nl) begin
            if (r_line == RW'(ROWS - 1)) begin
                n_vld[r_top] = 1'b0;
                n_top = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
            end else begin
                n_line = r_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_line    <= '0;
            r_top     <= '0;
            r_vld     <= '0;
            r_shown   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_line    <= n_line;
            r_top     <= n_top;
            r_vld     <= n_vld;
            r_shown   <= n_shown;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_step  <= n_step;
        r_ch    <= n_ch;
        r_sweep <= n_sweep;
        r_rd_ok <= n_rd_ok;
        r_hit   <= n_hit;
        r_cell  <= n_cell;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> sv/ttcb_checker.sv
// Port-level checker of the character buffer and its bind to the top level.
`include "text_terminal_char_buffer_macros.svh"

module ttcb_checker #(
    parameter int COLS = ttcb_pkg::DEF_COLS,
    parameter int ROWS = ttcb_pkg::DEF_ROWS
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ttcb_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ttcb_pkg::t_out o_out_data
);
    import ttcb_pkg::*;

    logic [OP_W-1:0] r_head_op;
    logic [OP_W-1:0] r_tail_op;
    logic [1:0]      r_op_cnt;
    logic            push;
    logic            pop;

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_out_valid && i_out_ready;

    // Track the commands whose results are still owed; the head one is on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_cnt <= '0;
        end else begin
            r_op_cnt <= r_op_cnt + 2'(push) - 2'(pop);
        end
        if (pop) begin
            r_head_op <= (r_op_cnt == 2'd2) ? r_tail_op : i_in_data.operation;
        end else if (push && (r_op_cnt == 2'd0)) begin
            r_head_op <= i_in_data.operation;
        end
        if (push) begin
            r_tail_op <= i_in_data.operation;
        end
    end

    `TTCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `TTCB_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "command accepted while another is in progress")
    `TTCB_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, o_out_valid, (32'(o_out_data.cursor_col) < 32'(COLS)) && (32'(o_out_data.cursor_row) < 32'(ROWS)), "cursor outside the screen")
    `TTCB_ASSERT_NOW(a_cell_zero, i_clk, i_rst_n, o_out_valid && (r_head_op != OP_READ_CELL), o_out_data.cell_value == '0, "cell value nonzero for a command other than a read")

endmodule

bind text_terminal_char_buffer ttcb_checker #(.COLS(COLS), .ROWS(ROWS)) u_ttcb_checker (.*);
